@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the probe/replace cache
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TTPR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define TTPR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/ttpr_pkg.sv @@
// ----------------------------------------------------------------------------
// ttpr_pkg
// shared types, codes and helpers of the probe/replace cache
// ----------------------------------------------------------------------------
package ttpr_pkg;

    localparam int INDEX_BITS_DEF = 12;
    localparam int PROBES_DEF     = 7;
    localparam int CELLS          = 42;

    localparam int STONE_W  = 42;
    localparam int SCORE_W  = 16;
    localparam int DEPTH_W  = 6;
    localparam int EFFORT_W = 32;
    localparam int THR_W    = 15;
    localparam int FILL_W   = 13;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 15;
    localparam int SUM_W    = 8;

    localparam logic [STONE_W-1:0] CELL_MASK =
        (CELLS >= STONE_W) ? '1 : STONE_W'((64'd1 << CELLS) - 64'd1);

    // operation codes
    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_PREPARE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_SKIPPED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MIN_DEPTH = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_WIN_THR   = 2'd1;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = 6'd2;
    localparam logic [THR_W-1:0]   WIN_THR_RST   = 15'd32767;

    typedef struct packed {
        logic                e_valid;
        logic [DEPTH_W-1:0]  e_depth;
        logic [STONE_W-1:0]  e_first;
        logic [STONE_W-1:0]  e_second;
        logic                e_turn;
        logic [SCORE_W-1:0]  e_score;
        logic [EFFORT_W-1:0] e_effort;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sweep;
        logic clr;
        logic chk;
        logic last;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic fin;
    } t_stat;

    function automatic logic is_win(input logic [SCORE_W-1:0] s,
                                    input logic [THR_W-1:0] thr);
        logic [SCORE_W-1:0] mag;
        mag = s[SCORE_W-1] ? (~s + SCORE_W'(1)) : s;
        return mag >= {1'b0, thr};
    endfunction

endpackage

@@ hw/rtl/transposition_table_probe_replace.sv @@
// ----------------------------------------------------------------------------
// transposition_table_probe_replace
// position cache with linear probing, shallowest-slot replacement and sweep
// ----------------------------------------------------------------------------
// A word is taken at a clock edge with i_start high and o_busy low; its
// result appears for exactly one cycle with o_done high and must be taken
// then, since the receiver cannot stall the block. After reset the block
// runs a clearing pass over every entry with o_busy high; configuration
// writes are taken at any time. A lookup or insert issues one read of the
// entry memory per cycle, with each check in the cycle after its read; a
// probe run can stop early, and skipped words and unused op codes go
// straight to the result strobe. A prepare sweep streams every entry
// through a three-stage read, count and write-back pipeline. The entry
// memory has a single port pair. The user must see that configuration is
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module transposition_table_probe_replace import ttpr_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int PROBES     = PROBES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_op,
    input  logic [63:0]         i_raw_hash,
    input  logic [STONE_W-1:0]  i_first_stones,
    input  logic [STONE_W-1:0]  i_second_stones,
    input  logic                i_turn,
    input  logic [SCORE_W-1:0]  i_value,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic [EFFORT_W-1:0] i_effort,
    // result side
    output logic                o_done,
    output logic                o_hit,
    output logic [SCORE_W-1:0]  o_found_value,
    output logic [1:0]          o_status,
    output logic [FILL_W-1:0]   o_fill_count,
    output logic [EFFORT_W-1:0] o_saved_effort,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data
);

    t_cmd                  cmd;
    t_stat                 stat;
    logic [INDEX_BITS-1:0] cmd_idx;
    logic                  start_ok;

    // registers are always writable
    assign o_cfg_ready = 1'b1;
    assign start_ok    = i_start && !o_busy;

    ttpr_ctrl #(
        .INDEX_BITS(INDEX_BITS),
        .PROBES    (PROBES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start_ok),
        .i_op     (i_op),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_cmd_idx(cmd_idx),
        .o_busy   (o_busy)
    );

    ttpr_datapath #(
        .INDEX_BITS(INDEX_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cmd_idx      (cmd_idx),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_raw_hash     (i_raw_hash),
        .i_first_stones (i_first_stones),
        .i_second_stones(i_second_stones),
        .i_turn         (i_turn),
        .i_value        (i_value),
        .i_depth        (i_depth),
        .i_effort       (i_effort),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_found_value  (o_found_value),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count),
        .o_saved_effort (o_saved_effort)
    );

endmodule

@@ hw/rtl/ttpr_datapath.sv @@
// ----------------------------------------------------------------------------
// ttpr_datapath
// entry memory, index fold, probe evaluation, sweep pipeline and counters
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttpr_datapath import ttpr_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [INDEX_BITS-1:0] i_cmd_idx,
    output t_stat                 o_stat,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IW-1:0]     i_cfg_index,
    input  logic [CFG_DW-1:0]     i_cfg_data,
    input  logic [1:0]            i_op,
    input  logic [63:0]           i_raw_hash,
    input  logic [STONE_W-1:0]    i_first_stones,
    input  logic [STONE_W-1:0]    i_second_stones,
    input  logic                  i_turn,
    input  logic [SCORE_W-1:0]    i_value,
    input  logic [DEPTH_W-1:0]    i_depth,
    input  logic [EFFORT_W-1:0]   i_effort,
    output logic                  o_done,
    output logic                  o_hit,
    output logic [SCORE_W-1:0]    o_found_value,
    output logic [1:0]            o_status,
    output logic [FILL_W-1:0]     o_fill_count,
    output logic [EFFORT_W-1:0]   o_saved_effort
);

    localparam int TABLE_SIZE = 1 << INDEX_BITS;
    localparam int VT_W       = INDEX_BITS + 1;
    localparam int NCHUNK     = 63 / INDEX_BITS + 1;

    function automatic logic [INDEX_BITS-1:0] fold(input logic [63:0] key);
        logic signed [63:0]    w;
        logic [INDEX_BITS-1:0] s;
        w = signed'(key);
        s = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            s = s + w[INDEX_BITS-1:0];
            w = w >>> INDEX_BITS;
        end
        return s;
    endfunction

    logic [$bits(t_entry)-1:0] mem [TABLE_SIZE];

    logic [DEPTH_W-1:0]    r_min_depth;
    logic [THR_W-1:0]      r_win_thr;

    logic [1:0]            r_op;
    logic [STONE_W-1:0]    r_first;
    logic [STONE_W-1:0]    r_second;
    logic                  r_turn;
    logic [SCORE_W-1:0]    r_value;
    logic [DEPTH_W-1:0]    r_depth;
    logic [EFFORT_W-1:0]   r_effort;
    logic [INDEX_BITS-1:0] r_base;

    t_entry                r_rd_data;
    logic [INDEX_BITS-1:0] r_rd_addr;

    logic                  r_have;
    logic [INDEX_BITS-1:0] r_best;
    logic [DEPTH_W-1:0]    r_best_depth;
    logic                  r_best_valid;

    logic                  r_sv1;
    logic                  r_sv2;
    logic [INDEX_BITS-1:0] r_s2_addr;
    logic                  r_s2_cand;
    logic [SUM_W-1:0]      r_s2_sum;

    logic [VT_W-1:0]       r_valid_total;
    logic [EFFORT_W-1:0]   r_sum;
    logic                  r_done;
    logic                  r_hit;
    logic [SCORE_W-1:0]    r_found;
    logic [1:0]            r_status;

    logic [INDEX_BITS-1:0] rd_addr;
    logic                  is_lookup;
    logic                  is_insert;
    logic                  ins_skip;
    logic                  match;
    logic                  win_d;
    logic                  usable;
    logic                  stop;
    logic                  fin;
    logic                  n_have;
    logic [INDEX_BITS-1:0] n_best;
    logic [DEPTH_W-1:0]    n_best_depth;
    logic                  n_best_valid;
    logic                  lk_hit;
    logic                  ins_write;
    logic                  sw_clear;
    logic                  we;
    logic [INDEX_BITS-1:0] wa;
    t_entry                wd;
    t_entry                new_entry;
    logic [EFFORT_W:0]     sum_ext;
    logic [EFFORT_W-1:0]   n_sum;
    logic [VT_W-1:0]       n_valid_total;
    logic [SUM_W-1:0]      s1_sum;

    assign rd_addr   = (i_cmd.sweep || i_cmd.clr) ? i_cmd_idx : r_base + i_cmd_idx;
    assign is_lookup = (r_op == OP_LOOKUP);
    assign is_insert = (r_op == OP_INSERT);

    assign ins_skip = r_rd_data.e_depth > r_depth;
    assign match    = (r_rd_data.e_first == r_first) && (r_rd_data.e_second == r_second)
                   && (r_rd_data.e_turn == r_turn);
    assign win_d    = is_win(r_rd_data.e_score, r_win_thr);
    assign usable   = !((r_rd_data.e_depth < r_depth) && !win_d);
    assign stop     = is_lookup ? (!r_rd_data.e_valid || match)
                                : (!ins_skip && !r_rd_data.e_valid);
    assign fin      = i_cmd.chk && (stop || i_cmd.last);

    // replacement choice: empty slot wins, else shallowest eligible slot
    always_comb begin
        n_have       = r_have;
        n_best       = r_best;
        n_best_depth = r_best_depth;
        n_best_valid = r_best_valid;
        if (!ins_skip && (!r_rd_data.e_valid || !r_have ||
                          r_rd_data.e_depth < r_best_depth)) begin
            n_have       = 1'b1;
            n_best       = r_rd_addr;
            n_best_depth = r_rd_data.e_depth;
            n_best_valid = r_rd_data.e_valid;
        end
    end

    assign lk_hit    = fin && is_lookup && r_rd_data.e_valid && match && usable;
    assign ins_write = fin && is_insert && n_have;
    assign sw_clear  = r_sv2 && r_s2_cand && (r_s2_sum != SUM_W'(r_depth));

    assign sum_ext = {1'b0, r_sum} + {1'b0, r_rd_data.e_effort};
    assign n_sum   = sum_ext[EFFORT_W] ? '1 : sum_ext[EFFORT_W-1:0];

    assign s1_sum = SUM_W'(r_rd_data.e_depth) + SUM_W'($countones(r_rd_data.e_first))
                  + SUM_W'($countones(r_rd_data.e_second));

    always_comb begin
        new_entry.e_valid  = 1'b1;
        new_entry.e_depth  = r_depth;
        new_entry.e_first  = r_first;
        new_entry.e_second = r_second;
        new_entry.e_turn   = r_turn;
        new_entry.e_score  = r_value;
        new_entry.e_effort = r_effort;
    end

    always_comb begin
        we = 1'b0;
        wa = i_cmd_idx;
        wd = '0;
        priority if (i_cmd.clr) begin
            we = 1'b1;
        end else if (ins_write) begin
            we = 1'b1;
            wa = n_best;
            wd = new_entry;
        end else if (sw_clear) begin
            we = 1'b1;
            wa = r_s2_addr;
        end
    end

    always_comb begin
        n_valid_total = r_valid_total;
        if (ins_write && !n_best_valid) begin
            n_valid_total = r_valid_total + VT_W'(1);
        end else if (sw_clear) begin
            n_valid_total = r_valid_total - VT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_first  <= i_first_stones & CELL_MASK;
            r_second <= i_second_stones & CELL_MASK;
            r_turn   <= i_turn;
            r_value  <= i_value;
            r_depth  <= i_depth;
            r_effort <= i_effort;
            r_base   <= fold(i_raw_hash);
        end
        if (i_cmd.chk && is_insert) begin
            r_best       <= n_best;
            r_best_depth <= n_best_depth;
            r_best_valid <= n_best_valid;
        end
        r_s2_addr <= r_rd_addr;
        r_s2_cand <= r_rd_data.e_valid && !win_d;
        r_s2_sum  <= s1_sum;
        if (i_cmd.load) begin
            r_found <= '0;
        end else if (lk_hit) begin
            r_found <= r_rd_data.e_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth   <= MIN_DEPTH_RST;
            r_win_thr     <= WIN_THR_RST;
            r_have        <= 1'b0;
            r_sv1         <= 1'b0;
            r_sv2         <= 1'b0;
            r_valid_total <= '0;
            r_sum         <= '0;
            r_done        <= 1'b0;
            r_hit         <= 1'b0;
            r_status      <= ST_DONE;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_MIN_DEPTH) begin
                r_min_depth <= i_cfg_data[DEPTH_W-1:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_WIN_THR) begin
                r_win_thr <= i_cfg_data[THR_W-1:0];
            end
            r_sv1         <= i_cmd.sweep;
            r_sv2         <= r_sv1;
            r_valid_total <= n_valid_total;
            r_done        <= i_cmd.emit;
            if (i_cmd.load) begin
                r_have   <= 1'b0;
                r_hit    <= 1'b0;
                r_status <= ((i_op == OP_LOOKUP || i_op == OP_INSERT) && o_stat.skip)
                            ? ST_SKIPPED : ST_DONE;
            end else begin
                if (i_cmd.chk && is_insert) begin
                    r_have <= n_have;
                end
                if (lk_hit) begin
                    r_hit <= 1'b1;
                    r_sum <= n_sum;
                end
                if (fin && is_insert && !n_have) begin
                    r_status <= ST_REFUSED;
                end
            end
        end
    end

    assign o_stat.skip = i_depth < r_min_depth;
    assign o_stat.fin  = fin;

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_found_value  = r_found;
    assign o_status       = r_status;
    assign o_fill_count   = FILL_W'(r_valid_total);
    assign o_saved_effort = r_sum;

    `TTPR_ASSERT(a_fill_bound, r_valid_total <= VT_W'(TABLE_SIZE), "fill count overflow")
    `TTPR_ASSERT(a_miss_zero, o_done |-> (o_hit || o_found_value == '0), "value without hit")
    `TTPR_ASSERT(a_refuse_op, (o_done && o_status == ST_REFUSED) |-> (r_op == OP_INSERT), "refused non-insert")

endmodule

@@ hw/rtl/ttpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttpr_ctrl
// sequencer for clear pass, probe runs, prepare sweep and result strobe
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttpr_ctrl import ttpr_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int PROBES     = PROBES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_op,
    input  t_stat                 i_stat,
    output t_cmd                  o_cmd,
    output logic [INDEX_BITS-1:0] o_cmd_idx,
    output logic                  o_busy
);

    localparam int PW = $clog2(PROBES + 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PROBE  = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [INDEX_BITS-1:0] r_cnt, n_cnt;
    logic [PW-1:0]         r_iss, n_iss;
    logic                  r_chk_v, n_chk_v;
    logic [PW-1:0]         r_chk_idx, n_chk_idx;
    logic                  r_drain, n_drain;
    logic                  issue;

    assign issue = r_iss < PW'(PROBES);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_iss     = r_iss;
        n_chk_v   = 1'b0;
        n_chk_idx = r_iss;
        n_drain   = r_drain;
        o_cmd     = '0;
        o_cmd_idx = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_cnt     = r_cnt + INDEX_BITS'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_iss      = '0;
                    if (i_op == OP_PREPARE) begin
                        n_state = S_SWEEP;
                    end else if ((i_op == OP_LOOKUP || i_op == OP_INSERT) && !i_stat.skip) begin
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_PROBE: begin
                o_cmd_idx  = INDEX_BITS'(r_iss);
                o_cmd.chk  = r_chk_v;
                o_cmd.last = r_chk_idx == PW'(PROBES - 1);
                n_chk_v    = issue;
                if (issue) begin
                    n_iss = r_iss + PW'(1);
                end
                if (i_stat.fin) begin
                    n_state = S_FINISH;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                n_cnt       = r_cnt + INDEX_BITS'(1);
                if (r_cnt == '1) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_iss     <= '0;
            r_chk_v   <= 1'b0;
            r_chk_idx <= '0;
            r_drain   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_iss     <= n_iss;
            r_chk_v   <= n_chk_v;
            r_chk_idx <= n_chk_idx;
            r_drain   <= n_drain;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `TTPR_ASSERT(a_finish_idle, (r_state == S_FINISH) |=> !o_busy, "no return to idle after result")

endmodule

@@ tb/position_cache_checker.sv @@
// ----------------------------------------------------------------------------
// position_cache_checker
// watches the command, result and configuration channels of the position
// cache, keeps its own copy of the table and compares every result word
// ----------------------------------------------------------------------------
module position_cache_checker import ttpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                o_busy,
    input  logic [1:0]          i_op,
    input  logic [63:0]         i_raw_hash,
    input  logic [STONE_W-1:0]  i_first_stones,
    input  logic [STONE_W-1:0]  i_second_stones,
    input  logic                i_turn,
    input  logic [SCORE_W-1:0]  i_value,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic [EFFORT_W-1:0] i_effort,
    input  logic                o_done,
    input  logic                o_hit,
    input  logic [SCORE_W-1:0]  o_found_value,
    input  logic [1:0]          o_status,
    input  logic [FILL_W-1:0]   o_fill_count,
    input  logic [EFFORT_W-1:0] o_saved_effort,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    output int                  fail_count,
    output int                  replies_due
);

    localparam int SLOTS  = 1 << INDEX_BITS_DEF;
    localparam int PROBES = PROBES_DEF;

    typedef struct packed {
        logic                hit;
        logic [SCORE_W-1:0]  found;
        logic [1:0]          status;
        logic [FILL_W-1:0]   fill;
        logic [EFFORT_W-1:0] saved;
    } t_reply;

    // shadow table
    bit                  slot_used  [SLOTS];
    logic [DEPTH_W-1:0]  slot_depth [SLOTS];
    logic [STONE_W-1:0]  slot_first [SLOTS];
    logic [STONE_W-1:0]  slot_second[SLOTS];
    logic                slot_turn  [SLOTS];
    logic [SCORE_W-1:0]  slot_score [SLOTS];
    logic [EFFORT_W-1:0] slot_effort[SLOTS];
    int                  used_slots;
    logic [EFFORT_W-1:0] effort_saved;
    logic [DEPTH_W-1:0]  min_depth;
    logic [THR_W-1:0]    win_thr;

    t_reply expected_replies[$];

    assign replies_due = expected_replies.size();

    function automatic logic [INDEX_BITS_DEF-1:0] home_slot(input logic [63:0] key);
        logic signed [63:0]        w;
        logic [INDEX_BITS_DEF-1:0] acc;
        w   = key;
        acc = '0;
        // five sign-filling shifts, six chunks summed mod table size
        for (int i = 0; i < 63 / INDEX_BITS_DEF; i++) begin
            acc = acc + w[INDEX_BITS_DEF-1:0];
            w   = w >>> INDEX_BITS_DEF;
        end
        acc = acc + w[INDEX_BITS_DEF-1:0];
        return acc;
    endfunction

    function automatic bit scores_win(input logic [SCORE_W-1:0] s);
        int mag;
        mag = int'($signed(s));
        if (mag < 0) mag = -mag;
        return mag >= int'(win_thr);
    endfunction

    function automatic t_reply predict_cache_step(
        input logic [1:0] op, input logic [63:0] key,
        input logic [STONE_W-1:0] first, input logic [STONE_W-1:0] second,
        input logic turn, input logic [SCORE_W-1:0] value,
        input logic [DEPTH_W-1:0] depth, input logic [EFFORT_W-1:0] effort);
        t_reply r;
        int     base;
        int     slot;
        int     best;
        bit     have;
        r     = '0;
        first  = first & CELL_MASK;
        second = second & CELL_MASK;
        if (op == OP_LOOKUP || op == OP_INSERT) begin
            base = int'(home_slot(key));
            if (depth < min_depth) begin
                r.status = ST_SKIPPED;
            end else if (op == OP_LOOKUP) begin
                for (int i = 0; i < PROBES; i++) begin
                    slot = (base + i) % SLOTS;
                    if (!slot_used[slot]) break;
                    if (slot_first[slot] == first && slot_second[slot] == second &&
                        slot_turn[slot] == turn) begin
                        // shallower entries only count when they hold a win
                        if (!(slot_depth[slot] < depth && !scores_win(slot_score[slot]))) begin
                            r.hit   = 1'b1;
                            r.found = slot_score[slot];
                            if (effort_saved > 32'hFFFF_FFFF - slot_effort[slot])
                                effort_saved = 32'hFFFF_FFFF;
                            else
                                effort_saved = effort_saved + slot_effort[slot];
                        end
                        break;
                    end
                end
            end else begin
                have = 1'b0;
                best = 0;
                for (int i = 0; i < PROBES; i++) begin
                    slot = (base + i) % SLOTS;
                    if (slot_depth[slot] > depth) continue;
                    if (!slot_used[slot]) begin
                        best = slot;
                        have = 1'b1;
                        break;
                    end
                    if (!have || slot_depth[slot] < slot_depth[best]) begin
                        best = slot;
                        have = 1'b1;
                    end
                end
                if (!have) begin
                    r.status = ST_REFUSED;
                end else begin
                    if (!slot_used[best]) used_slots++;
                    slot_used[best]   = 1'b1;
                    slot_first[best]  = first;
                    slot_second[best] = second;
                    slot_turn[best]   = turn;
                    slot_effort[best] = effort;
                    slot_depth[best]  = depth;
                    slot_score[best]  = value;
                end
            end
        end else if (op == OP_PREPARE) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (!slot_used[s] || scores_win(slot_score[s])) continue;
                if (int'(slot_depth[s]) + $countones(slot_first[s]) +
                    $countones(slot_second[s]) == int'(depth)) continue;
                slot_used[s]   = 1'b0;
                slot_depth[s]  = '0;
                slot_score[s]  = '0;
                slot_effort[s] = '0;
                used_slots--;
            end
        end
        r.fill  = used_slots[FILL_W-1:0];
        r.saved = effort_saved;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_used[s]  = 1'b0;
                slot_depth[s] = '0;
            end
            used_slots   = 0;
            effort_saved = '0;
            min_depth    = MIN_DEPTH_RST;
            win_thr      = WIN_THR_RST;
            fail_count   = 0;
            expected_replies.delete();
        end else begin
            if (o_done) begin
                got = '{o_hit, o_found_value, o_status, o_fill_count, o_saved_effort};
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found_value expected %0d actual %0d", $time,
                                 $signed(want.found), $signed(got.found));
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        fail_count++;
                    end
                    if (got.fill !== want.fill) begin
                        $display("%0t: fill_count expected %0d actual %0d", $time,
                                 want.fill, got.fill);
                        fail_count++;
                    end
                    if (got.saved !== want.saved) begin
                        $display("%0t: saved_effort expected %h actual %h", $time,
                                 want.saved, got.saved);
                        fail_count++;
                    end
                end
            end
            if (i_start && !o_busy)
                expected_replies.push_back(predict_cache_step(i_op, i_raw_hash,
                    i_first_stones, i_second_stones, i_turn, i_value, i_depth, i_effort));
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MIN_DEPTH) min_depth = i_cfg_data[DEPTH_W-1:0];
                else if (i_cfg_index == CFG_WIN_THR) win_thr = i_cfg_data[THR_W-1:0];
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives directed and random cache commands through several register
// settings with random gaps; the checker beside the block judges each word
// ----------------------------------------------------------------------------
module testbench import ttpr_pkg::*;;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL        = 48;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    logic [1:0]          i_op;
    logic [63:0]         i_raw_hash;
    logic [STONE_W-1:0]  i_first_stones;
    logic [STONE_W-1:0]  i_second_stones;
    logic                i_turn;
    logic [SCORE_W-1:0]  i_value;
    logic [DEPTH_W-1:0]  i_depth;
    logic [EFFORT_W-1:0] i_effort;
    logic                o_done;
    logic                o_hit;
    logic [SCORE_W-1:0]  o_found_value;
    logic [1:0]          o_status;
    logic [FILL_W-1:0]   o_fill_count;
    logic [EFFORT_W-1:0] o_saved_effort;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_data;
    int                  fail_count;
    int                  replies_due;

    // positions reused by the random part so lookups find what was stored
    logic [63:0]        pos_hash  [POOL];
    logic [STONE_W-1:0] pos_first [POOL];
    logic [STONE_W-1:0] pos_second[POOL];
    logic               pos_turn  [POOL];

    bit no_gaps;

    transposition_table_probe_replace u_top (.*);
    position_cache_checker u_check (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // one command word; start stays high into the next word when no gap is drawn
    task automatic issue(input logic [1:0] op, input logic [63:0] h,
                         input logic [STONE_W-1:0] f, input logic [STONE_W-1:0] s,
                         input logic t, input logic [SCORE_W-1:0] v,
                         input logic [DEPTH_W-1:0] d, input logic [EFFORT_W-1:0] e);
        int gap;
        i_op = op;  i_raw_hash = h;  i_first_stones = f;  i_second_stones = s;
        i_turn = t; i_value = v;     i_depth = d;         i_effort = e;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        gap = no_gaps ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold off until every word has come back, plus the block's own latency
    task automatic drain();
        i_start = 1'b0;
        while (replies_due != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic logic [STONE_W-1:0] wide_rand();
        return STONE_W'({$urandom, $urandom});
    endfunction

    task automatic random_phase(input int count);
        int                 p;
        int                 kind;
        logic [EFFORT_W-1:0] eff;
        logic [SCORE_W-1:0]  val;
        logic [DEPTH_W-1:0]  dep;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0) drain();
            p    = $urandom_range(0, POOL - 1);
            kind = $urandom_range(0, 99);
            eff  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 65535);
            val  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 4000) - 2000);
            dep  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 20));
            if (kind < 45)
                issue(OP_LOOKUP, pos_hash[p], pos_first[p], pos_second[p], pos_turn[p],
                      16'($urandom), dep, $urandom);
            else if (kind < 85)
                issue(OP_INSERT, pos_hash[p], pos_first[p], pos_second[p], pos_turn[p],
                      val, dep, eff);
            else if (kind < 89)
                issue(OP_PREPARE, {$urandom, $urandom}, wide_rand(), wide_rand(),
                      1'($urandom), 16'($urandom), 6'($urandom_range(8, 40)), $urandom);
            else if (kind < 92)
                issue(2'd3, {$urandom, $urandom}, wide_rand(), wide_rand(), 1'($urandom),
                      16'($urandom), 6'($urandom), $urandom);
            else
                // noise: lookup or insert, any field value
                issue(2'($urandom_range(0, 3) == 3 ? OP_LOOKUP : $urandom_range(0, 1)),
                      {$urandom, $urandom}, wide_rand(), wide_rand(), 1'($urandom),
                      16'($urandom), 6'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [63:0] keys[8];
        i_rst_n = 1'b0;   i_start = 1'b0;    i_op = OP_LOOKUP;  i_raw_hash = '0;
        i_first_stones = '0; i_second_stones = '0; i_turn = 1'b0; i_value = '0;
        i_depth = '0;     i_effort = '0;     i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIN_DEPTH;  i_cfg_data = '0;
        no_gaps = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values, written explicitly
        write_reg(CFG_MIN_DEPTH, 15'(MIN_DEPTH_RST));
        write_reg(CFG_WIN_THR, 15'(WIN_THR_RST));

        // directed words
        issue(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd0, 6'd5,
              32'd0);  // empty
        issue(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd0, 6'd0,
              32'd0);  // skipped
        issue(OP_INSERT, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd7, 6'd1,
              32'd5);  // skipped
        issue(OP_INSERT, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd77, 6'd5,
              32'd100);
        issue(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd0, 6'd5,
              32'd0);  // hit
        issue(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd0, 6'd6,
              32'd0);  // shallower
        issue(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b1, 16'd0, 6'd5,
              32'd0);  // turn differs
        // duplicate copy lands in the next slot, the first copy still decides
        issue(OP_INSERT, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd99, 6'd7,
              32'd7);
        issue(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 42'h3, 42'h30, 1'b0, 16'd0, 6'd7,
              32'd0);
        // win scores at both extremes hit at any depth
        issue(OP_INSERT, 64'hFFFF_0000_FFFF_0000, '1, '0, 1'b1, 16'h8000, 6'd3, 32'hFFFF_FFFF);
        issue(OP_LOOKUP, 64'hFFFF_0000_FFFF_0000, '1, '0, 1'b1, 16'd0, 6'd63, 32'd0);
        issue(OP_INSERT, 64'h8000_0000_0000_0001, '0, '1, 1'b0, 16'h7FFF, 6'd63, 32'hFFFF_FFFF);
        issue(OP_LOOKUP, 64'h8000_0000_0000_0001, '0, '1, 1'b0, 16'd0, 6'd63, 32'd0);
        issue(2'd3, '1, '1, '1, 1'b1, '1, '1, '1);
        // fill a probe window with deep entries, then a shallow insert is refused
        for (int i = 0; i < 7; i++)
            issue(OP_INSERT, 64'h0000_0000_0000_0ABC, 42'(i + 1), 42'h100, 1'b0,
                  16'(i), 6'd10, 32'(i));
        issue(OP_INSERT, 64'h0000_0000_0000_0ABC, 42'h77, 42'h0, 1'b0, 16'd1, 6'd3, 32'd1);
        issue(OP_INSERT, 64'h0000_0000_0000_0ABC, 42'h77, 42'h0, 1'b0, 16'd2, 6'd10, 32'd2);
        issue(OP_PREPARE, '0, '0, '0, 1'b0, 16'd0, 6'd11, 32'd0);
        issue(OP_PREPARE, '0, '0, '0, 1'b0, 16'd0, 6'd63, 32'd0);
        drain();

        // sparse stone masks keep depth plus stone count within prepare targets
        foreach (keys[k]) keys[k] = {$urandom, $urandom};
        for (int p = 0; p < POOL; p++) begin
            pos_hash[p]   = keys[$urandom_range(0, 7)];
            pos_first[p]  = wide_rand() & wide_rand() & wide_rand();
            pos_second[p] = wide_rand() & wide_rand() & wide_rand();
            pos_turn[p]   = 1'($urandom);
        end

        random_phase(280);
        drain();
        write_reg(CFG_MIN_DEPTH, 15'd0);
        write_reg(CFG_WIN_THR, 15'd0);
        random_phase(250);
        drain();
        write_reg(CFG_MIN_DEPTH, 15'd63);
        write_reg(CFG_WIN_THR, 15'd32767);
        random_phase(60);
        drain();
        write_reg(CFG_MIN_DEPTH, 15'($urandom_range(3, 8)));
        write_reg(CFG_WIN_THR, 15'($urandom_range(300, 1500)));
        random_phase(300);
        drain();
        write_reg(CFG_MIN_DEPTH, 15'd1);
        write_reg(CFG_WIN_THR, 15'($urandom_range(0, 32767)));
        random_phase(300);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && replies_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
